/* src/tvc_pkg.sv */
`default_nettype none

package tvc_pkg;

  // Table geometry.
  localparam int CACHE_ENTRIES = 16;
  localparam int IDX_W = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;

  // Width of the stored transaction id; ids are compared modulo 2^TID_BITS.
  localparam int TID_BITS = 15;
  typedef logic [TID_BITS-1:0] tid_t;

  // Configuration register map.
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-1:0] ADDR_WINDOW_SIZE = 3'd0;
  localparam logic [14:0] WINDOW_RESET = 15'd16384;

  // Operation codes.
  localparam logic OP_VALIDATE = 1'b0;
  localparam logic OP_SET      = 1'b1;

  // Status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_FAIL      = 2'd1;
  localparam logic [1:0] ST_NO_CACHE  = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  typedef struct packed {
    logic        opcode;
    logic [31:0] remote_addr;
    logic [15:0] remote_port;
    logic [31:0] local_addr;
    logic [15:0] local_port;
    logic [14:0] received_tid;
    logic        new_flag;
    logic        no_cache_flag;
  } in_word_t;

  typedef struct packed {
    logic [1:0] status;
    logic       insert_dropped;
  } out_word_t;

  // Lookup key: the address four-tuple.
  typedef logic [95:0] key_t;

endpackage

`default_nettype wire

/* src/tid_window_validation_cache.sv */
`default_nettype none

// Channel   Direction  Handshake                   Content
// in_       input      in_valid / in_ready         one validate or set word
// out_      output     out_valid / out_ready       status and insert_dropped
// cfg_      input      psel penable pwrite pready  window_size at address 0
//
// A word passes from acceptance to the result register through S_SCAN,
// S_LAST, S_EXEC and S_DONE. A single compare unit walks the key memory one
// entry per cycle in S_SCAN, S_LAST drains the registered read, S_EXEC
// updates the table and S_DONE loads the output register.
// in_ready is high only while the sequencer is idle, so a new word is taken
// only once the previous one has left S_DONE; a finished result may still
// wait in the output register while the next word is accepted.
// Reset (rst_n, synchronous, active low) empties the table at once through
// the per-entry valid bits and restores window_size to 16384.
// A stalled output holds the sequencer in its final state until the register
// frees up.
module tid_window_validation_cache (
  input  wire                              clk,
  input  wire                              rst_n,
  // Input channel.
  input  wire                              in_valid,
  output logic                             in_ready,
  input  wire tvc_pkg::in_word_t           in_data,
  // Result channel.
  output logic                             out_valid,
  input  wire                              out_ready,
  output tvc_pkg::out_word_t               out_data,
  // Configuration port.
  input  wire                              psel,
  input  wire                              penable,
  input  wire                              pwrite,
  input  wire [tvc_pkg::CFG_ADDR_W-1:0]    paddr,
  input  wire [tvc_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [tvc_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready
);

  // Sequencer states.
  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_LAST = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  localparam logic [tvc_pkg::IDX_W-1:0] LAST_IDX =
    tvc_pkg::IDX_W'(tvc_pkg::CACHE_ENTRIES - 1);

  // The window register is written through a plain two-phase APB access.
  // Only bit 2 and up of the address select the register; the low two bits
  // are ignored.
  logic [14:0] window_r;
  logic        cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      window_r <= tvc_pkg::WINDOW_RESET;
    end else if (cfg_wr && paddr[tvc_pkg::CFG_ADDR_W-1:2] ==
                 tvc_pkg::ADDR_WINDOW_SIZE[tvc_pkg::CFG_ADDR_W-1:2]) begin
      window_r <= pwdata[14:0];
    end
  end

  always_comb begin
    if (paddr[tvc_pkg::CFG_ADDR_W-1:2] ==
        tvc_pkg::ADDR_WINDOW_SIZE[tvc_pkg::CFG_ADDR_W-1:2]) begin
      prdata = {{(tvc_pkg::CFG_DATA_W-15){1'b0}}, window_r};
    end else begin
      prdata = '0;
    end
  end

  // The table lives in two small memories, keys and last ids, with a
  // registered read port driven by the scan index. The valid bits are flops
  // so that reset empties the table at once.
  tvc_pkg::key_t key_mem [tvc_pkg::CACHE_ENTRIES];
  tvc_pkg::tid_t tid_mem [tvc_pkg::CACHE_ENTRIES];
  logic [tvc_pkg::CACHE_ENTRIES-1:0] valid_r, valid_nxt;

  logic [2:0]                 state_r, state_nxt;
  tvc_pkg::in_word_t          item_r, item_nxt;
  logic [tvc_pkg::IDX_W-1:0]  idx_r, idx_nxt;

  // Read pipeline: the word read for the entry issued last cycle.
  tvc_pkg::key_t              rd_key_r;
  tvc_pkg::tid_t              rd_tid_r;
  logic                       rd_ent_vld_r;
  logic [tvc_pkg::IDX_W-1:0]  rd_idx_r;
  logic                       rd_vld_r, rd_vld_nxt;

  // Scan results.
  logic                       found_r, found_nxt;
  logic [tvc_pkg::IDX_W-1:0]  hit_idx_r, hit_idx_nxt;
  tvc_pkg::tid_t              hit_tid_r, hit_tid_nxt;
  logic                       free_found_r, free_found_nxt;
  logic [tvc_pkg::IDX_W-1:0]  free_idx_r, free_idx_nxt;

  // Result staging and output register.
  tvc_pkg::out_word_t         res_r, res_nxt;
  tvc_pkg::out_word_t         out_data_r, out_data_nxt;
  logic                       out_valid_r, out_valid_nxt;

  // Memory write port.
  logic                       key_we, tid_we;
  logic [tvc_pkg::IDX_W-1:0]  wr_addr;
  tvc_pkg::tid_t              wr_tid;

  tvc_pkg::key_t              item_key;
  tvc_pkg::tid_t              item_tid;
  tvc_pkg::tid_t              fwd_gap;
  logic                       in_win;

  assign item_key = {item_r.remote_addr, item_r.local_addr,
                     item_r.remote_port, item_r.local_port};
  assign item_tid = tvc_pkg::tid_t'(item_r.received_tid);

  // The window arithmetic: forward distance from the stored id, with wrap,
  // compared against the window.
  assign fwd_gap = item_tid - hit_tid_r;
  assign in_win  = (fwd_gap != '0) && (32'(fwd_gap) <= 32'(window_r));

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    state_nxt      = state_r;
    item_nxt       = item_r;
    idx_nxt        = idx_r;
    rd_vld_nxt     = 1'b0;
    found_nxt      = found_r;
    hit_idx_nxt    = hit_idx_r;
    hit_tid_nxt    = hit_tid_r;
    free_found_nxt = free_found_r;
    free_idx_nxt   = free_idx_r;
    valid_nxt      = valid_r;
    res_nxt        = res_r;
    out_valid_nxt  = out_valid_r;
    out_data_nxt   = out_data_r;
    key_we         = 1'b0;
    tid_we         = 1'b0;
    wr_addr        = hit_idx_r;
    wr_tid         = item_tid;

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    // Compare the entry read in the previous cycle. At most one valid entry
    // matches a key, so the first hit is kept.
    if (rd_vld_r && rd_ent_vld_r && !found_r && rd_key_r == item_key) begin
      found_nxt   = 1'b1;
      hit_idx_nxt = rd_idx_r;
      hit_tid_nxt = rd_tid_r;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_nxt       = in_data;
          idx_nxt        = '0;
          found_nxt      = 1'b0;
          free_found_nxt = 1'b0;
          state_nxt      = S_SCAN;
        end
      end
      S_SCAN: begin
        rd_vld_nxt = 1'b1;
        // The lowest empty entry is the insert position.
        if (!valid_r[idx_r] && !free_found_r) begin
          free_found_nxt = 1'b1;
          free_idx_nxt   = idx_r;
        end
        if (idx_r == LAST_IDX) begin
          state_nxt = S_LAST;
        end else begin
          idx_nxt = idx_r + tvc_pkg::IDX_W'(1);
        end
      end
      S_LAST: begin
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        res_nxt.status         = tvc_pkg::ST_OK;
        res_nxt.insert_dropped = 1'b0;
        if (item_r.opcode == tvc_pkg::OP_SET) begin
          if (found_r) begin
            tid_we = 1'b1;
          end else begin
            res_nxt.status = tvc_pkg::ST_NOT_FOUND;
          end
        end else if (item_r.new_flag) begin
          // A new id resets the entry to zero and never passes.
          res_nxt.status = tvc_pkg::ST_FAIL;
          wr_tid         = '0;
          if (found_r) begin
            tid_we = 1'b1;
          end else if (free_found_r) begin
            tid_we             = 1'b1;
            key_we             = 1'b1;
            wr_addr            = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
          end else begin
            res_nxt.insert_dropped = 1'b1;
          end
        end else if (!found_r) begin
          if (item_r.no_cache_flag) begin
            res_nxt.status = tvc_pkg::ST_NO_CACHE;
          end else if (free_found_r) begin
            tid_we             = 1'b1;
            key_we             = 1'b1;
            wr_addr            = free_idx_r;
            valid_nxt[free_idx_r] = 1'b1;
          end else begin
            res_nxt.insert_dropped = 1'b1;
          end
        end else if (in_win) begin
          tid_we = 1'b1;
        end else begin
          res_nxt.status = tvc_pkg::ST_FAIL;
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = res_r;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      valid_r     <= '0;
      rd_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      rd_vld_r    <= rd_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r       <= item_nxt;
    idx_r        <= idx_nxt;
    found_r      <= found_nxt;
    hit_idx_r    <= hit_idx_nxt;
    hit_tid_r    <= hit_tid_nxt;
    free_found_r <= free_found_nxt;
    free_idx_r   <= free_idx_nxt;
    res_r        <= res_nxt;
    out_data_r   <= out_data_nxt;
  end

  // Key and id memories: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[wr_addr] <= item_key;
    end
    if (tid_we) begin
      tid_mem[wr_addr] <= wr_tid;
    end
    rd_key_r     <= key_mem[idx_r];
    rd_tid_r     <= tid_mem[idx_r];
    rd_ent_vld_r <= valid_r[idx_r];
    rd_idx_r     <= idx_r;
  end

endmodule

`default_nettype wire

/* src/tvc_checker.sv */
`default_nettype none

module tvc_props (
  input wire                        clk,
  input wire                        rst_n,
  input wire                        in_valid,
  input wire                        in_ready,
  input wire                        out_valid,
  input wire                        out_ready,
  input wire tvc_pkg::out_word_t    out_data
);

  // Each accepted word occupies the sequencer until its result is loaded.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input accepted twice in consecutive cycles");

  // A new result only appears while the sequencer was busy finishing a word.
  a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a word in flight");

  // No insert is attempted for an unknown no-cache initiator or a failed set.
  a_no_drop_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_data.status == tvc_pkg::ST_NO_CACHE ||
                  out_data.status == tvc_pkg::ST_NOT_FOUND)
    |-> !out_data.insert_dropped)
    else $error("insert_dropped set on a status that never inserts");

  // A stalled result holds.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

endmodule

bind tid_window_validation_cache tvc_props u_tvc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

/* bench/tvc_checker.sv */
`timescale 1ns / 100ps

module tvc_checker (
  input  wire                            clk,
  input  wire                            rst_n,
  input  wire                            in_valid,
  input  wire                            in_ready,
  input  tvc_pkg::in_word_t              in_data,
  input  wire                            out_valid,
  input  wire                            out_ready,
  input  tvc_pkg::out_word_t             out_data,
  input  wire                            psel,
  input  wire                            penable,
  input  wire                            pwrite,
  input  wire [tvc_pkg::CFG_ADDR_W-1:0]  paddr,
  input  wire [tvc_pkg::CFG_DATA_W-1:0]  pwdata,
  input  wire [tvc_pkg::CFG_DATA_W-1:0]  prdata,
  input  wire                            pready,
  output int                             mismatch_count,
  output int                             results_owed,
  output bit [3:0][31:0]                 status_seen,
  output int                             drops_seen
);

  logic [tvc_pkg::CACHE_ENTRIES-1:0] slot_used;
  tvc_pkg::key_t                     slot_key [tvc_pkg::CACHE_ENTRIES];
  tvc_pkg::tid_t                     slot_tid [tvc_pkg::CACHE_ENTRIES];
  logic [14:0]                       window_size;
  tvc_pkg::out_word_t                expected_q [$];
  int                                result_index;

  // Mirror of the initiator table: lookup takes the lowest matching valid
  // slot, an insert takes the lowest free slot and nothing is ever evicted.
  function automatic tvc_pkg::out_word_t predict_tid_status(input tvc_pkg::in_word_t w);
    tvc_pkg::key_t      k;
    int                 hit;
    int                 free_slot;
    int                 i;
    tvc_pkg::tid_t      fwd_gap;
    tvc_pkg::out_word_t r;
    k = {w.remote_addr, w.remote_port, w.local_addr, w.local_port};
    hit = -1;
    free_slot = -1;
    for (i = 0; i < tvc_pkg::CACHE_ENTRIES; i++) begin
      if (hit < 0 && slot_used[i] && slot_key[i] == k) hit = i;
      if (free_slot < 0 && !slot_used[i]) free_slot = i;
    end
    r.status = tvc_pkg::ST_OK;
    r.insert_dropped = 1'b0;
    if (w.opcode == tvc_pkg::OP_SET) begin
      if (hit >= 0) slot_tid[hit] = w.received_tid;
      else r.status = tvc_pkg::ST_NOT_FOUND;
    end else if (w.new_flag) begin
      r.status = tvc_pkg::ST_FAIL;
      if (hit >= 0) begin
        slot_tid[hit] = '0;
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_tid[free_slot] = '0;
      end else begin
        r.insert_dropped = 1'b1;
      end
    end else if (hit < 0) begin
      if (w.no_cache_flag) begin
        r.status = tvc_pkg::ST_NO_CACHE;
      end else if (free_slot >= 0) begin
        slot_used[free_slot] = 1'b1;
        slot_key[free_slot] = k;
        slot_tid[free_slot] = w.received_tid;
      end else begin
        r.insert_dropped = 1'b1;
      end
    end else begin
      // Forward distance wraps at the tid width; zero means a repeat.
      fwd_gap = w.received_tid - slot_tid[hit];
      if (fwd_gap != '0 && fwd_gap <= window_size) slot_tid[hit] = w.received_tid;
      else r.status = tvc_pkg::ST_FAIL;
    end
    return r;
  endfunction

  task automatic note_failure(input string what);
    mismatch_count++;
    if (mismatch_count <= 10) $display("[%0t] %s", $time, what);
  endtask

  always @(posedge clk) begin
    tvc_pkg::out_word_t want;
    if (!rst_n) begin
      slot_used = '0;
      window_size = tvc_pkg::WINDOW_RESET;
      expected_q.delete();
    end else begin
      if (psel && penable && pready && paddr == tvc_pkg::ADDR_WINDOW_SIZE) begin
        if (pwrite) begin
          window_size = pwdata[14:0];
        end else if (prdata[14:0] !== window_size) begin
          note_failure($sformatf("window_size readback: expected %0d, got %0d",
                                 window_size, prdata[14:0]));
        end
      end
      if ($isunknown(out_valid)) begin
        note_failure("out_valid is unknown after reset");
      end else if (out_valid && out_ready) begin
        result_index++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("result %0d arrived with no word outstanding",
                                 result_index));
        end else begin
          want = expected_q.pop_front();
          if (out_data.status !== want.status ||
              out_data.insert_dropped !== want.insert_dropped) begin
            note_failure($sformatf(
              "result %0d: expected status %0d dropped %0b, got status %0d dropped %0b",
              result_index, want.status, want.insert_dropped,
              out_data.status, out_data.insert_dropped));
          end
          status_seen[want.status] = status_seen[want.status] + 1;
          drops_seen += want.insert_dropped;
        end
      end
      if (in_valid && in_ready) expected_q.push_back(predict_tid_status(in_data));
    end
    results_owed = expected_q.size();
  end

endmodule

/* bench/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

  // The random part is split evenly over the window settings below.
  localparam int SETTINGS_COUNT = 6;
  localparam int WORDS_PER_SETTING = 225;

  typedef enum int {RX_OPEN, RX_CHOPPY, RX_THROTTLED} rx_pattern_t;

  logic                           clk;
  logic                           rst_n;
  logic                           in_valid;
  logic                           in_ready;
  tvc_pkg::in_word_t              in_data;
  logic                           out_valid;
  logic                           out_ready;
  tvc_pkg::out_word_t             out_data;
  logic                           psel;
  logic                           penable;
  logic                           pwrite;
  logic [tvc_pkg::CFG_ADDR_W-1:0] paddr;
  logic [tvc_pkg::CFG_DATA_W-1:0] pwdata;
  logic [tvc_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;

  int                             mismatch_count;
  int                             results_owed;
  bit [3:0][31:0]                 status_seen;
  int                             drops_seen;

  // One key per table slot. These are the initiators that fill the table in
  // the directed part; the random part mostly reuses them so that lookups hit.
  tvc_pkg::key_t                  pool_key [tvc_pkg::CACHE_ENTRIES];
  // The last tid that the sender believes each pooled initiator holds. It is
  // only a steering hint for picking ids near the window edges.
  tvc_pkg::tid_t                  pool_tid_guess [tvc_pkg::CACHE_ENTRIES];
  logic [14:0]                    window_now;
  int                             words_sent;
  int                             burst_left;
  int                             settings_run;
  rx_pattern_t                    rx_pattern;
  int                             rx_run_left;

  tid_window_validation_cache uut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  tvc_checker status_check (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_ready      (in_ready),
    .in_data       (in_data),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_data      (out_data),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .mismatch_count(mismatch_count),
    .results_owed  (results_owed),
    .status_seen   (status_seen),
    .drops_seen    (drops_seen)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // The receiver switches between stretches of steady acceptance, coin-flip
  // stalls and heavy throttling, so the result register sometimes backs up
  // while the next word is already being processed.
  always @(negedge clk) begin
    if (rx_run_left == 0) begin
      rx_pattern = rx_pattern_t'($urandom_range(0, 2));
      rx_run_left = $urandom_range(20, 200);
    end else begin
      rx_run_left--;
    end
    case (rx_pattern)
      RX_OPEN: begin
        out_ready <= 1'b1;
      end
      RX_CHOPPY: begin
        out_ready <= 1'($urandom_range(0, 1));
      end
      default: begin
        out_ready <= ($urandom_range(0, 7) == 0);
      end
    endcase
  end

  function automatic tvc_pkg::key_t fresh_key();
    tvc_pkg::key_t k;
    k = {$urandom(), $urandom(), $urandom()};
    return k;
  endfunction

  function automatic tvc_pkg::in_word_t build_word(input logic op, input tvc_pkg::key_t k,
                                                   input tvc_pkg::tid_t tid,
                                                   input logic fresh,
                                                   input logic cacheless);
    tvc_pkg::in_word_t w;
    w.opcode = op;
    {w.remote_addr, w.remote_port, w.local_addr, w.local_port} = k;
    w.received_tid = tid;
    w.new_flag = fresh;
    w.no_cache_flag = cacheless;
    return w;
  endfunction

  // Called at a falling edge. Presents one word and holds it until the block
  // takes it. The sender works in bursts: when a burst runs out it drops valid
  // for a random gap, otherwise valid stays high and the caller must present
  // the next word (or go quiet) in this same time step.
  task automatic send_word(input tvc_pkg::in_word_t w);
    int gap;
    logic [127:0] noise;
    in_data  <= w;
    in_valid <= 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
    words_sent++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 9);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 30);
      if (gap > 0) begin
        noise = {$urandom(), $urandom(), $urandom(), $urandom()};
        in_valid <= 1'b0;
        in_data  <= noise[$bits(tvc_pkg::in_word_t)-1:0];
        repeat (gap) @(negedge clk);
      end
    end
  endtask

  // Stops sending and waits until every outstanding word has its result.
  task automatic drain_results();
    in_valid <= 1'b0;
    while (results_owed != 0) @(negedge clk);
  endtask

  // One APB transfer to the window register. psel is left high so that a
  // following transfer can start its setup phase in the same step; the caller
  // releases psel after the last one.
  task automatic cfg_access(input logic write_op,
                            input logic [tvc_pkg::CFG_DATA_W-1:0] data);
    psel   <= 1'b1;
    pwrite <= write_op;
    paddr  <= tvc_pkg::ADDR_WINDOW_SIZE;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    @(negedge clk);
    penable <= 1'b0;
  endtask

  initial begin
    tvc_pkg::in_word_t              w;
    tvc_pkg::key_t                  k;
    tvc_pkg::tid_t                  tid;
    tvc_pkg::tid_t                  fwd_gap;
    logic [tvc_pkg::CFG_DATA_W-1:0] cfg_word;
    logic [127:0]                   noise;
    logic [14:0]                    window_plan [SETTINGS_COUNT];
    int                             slot;
    int                             flavor;
    int                             n;
    int                             s;

    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    psel      = 1'b0;
    penable   = 1'b0;
    pwrite    = 1'b0;
    paddr     = '0;
    pwdata    = '0;

    // Pool layout: slot 0 is a random base key, slots 1 to 4 differ from it in
    // exactly one field (inverted), slots 5 and 6 are the all-ones and all-zero
    // keys, the rest are random.
    pool_key[0] = fresh_key();
    pool_key[1] = pool_key[0] ^ {32'hFFFF_FFFF, 16'h0, 32'h0, 16'h0};
    pool_key[2] = pool_key[0] ^ {32'h0, 16'hFFFF, 32'h0, 16'h0};
    pool_key[3] = pool_key[0] ^ {32'h0, 16'h0, 32'hFFFF_FFFF, 16'h0};
    pool_key[4] = pool_key[0] ^ {32'h0, 16'h0, 32'h0, 16'hFFFF};
    pool_key[5] = '1;
    pool_key[6] = '0;
    for (slot = 7; slot < tvc_pkg::CACHE_ENTRIES; slot++) pool_key[slot] = fresh_key();

    window_plan[0] = 15'd0;
    window_plan[1] = 15'h7FFF;
    window_plan[2] = 15'd1;
    window_plan[3] = 15'($urandom_range(2, 32766));
    window_plan[4] = tvc_pkg::WINDOW_RESET;
    window_plan[5] = 15'($urandom_range(2, 32766));

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed part, at the reset window of 16384 and on an empty table.
    window_now = tvc_pkg::WINDOW_RESET;
    settings_run = 1;
    // A set for an initiator the table has never seen, then a validate from an
    // initiator that keeps no cache: neither may insert anything.
    send_word(build_word(tvc_pkg::OP_SET, pool_key[0], 15'd77, 1'b0, 1'b0));
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd5, 1'b0, 1'b1));
    // First real insert, then walk the window edges on that entry.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd0, 1'b0, 1'b0));
    // Repeat id.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd0, 1'b0, 1'b0));
    // One ahead.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd1, 1'b0, 1'b0));
    // At the edge.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd16385, 1'b0, 1'b0));
    // One past it.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd2, 1'b0, 1'b0));
    // Wraps to zero.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd0, 1'b0, 1'b0));
    // One behind.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'h7FFF, 1'b0, 1'b0));
    // A set ignores both flags; the next id wraps through zero.
    send_word(build_word(tvc_pkg::OP_SET, pool_key[0], 15'h7FFF, 1'b1, 1'b1));
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd0, 1'b0, 1'b0));
    // New flag on a known entry resets its id to zero and fails; a zero id
    // right after that is a repeat.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd9, 1'b1, 1'b1));
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[0], 15'd0, 1'b0, 1'b0));
    // New flag on an unknown initiator inserts it with id zero.
    send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[1], 15'd123, 1'b1, 1'b0));
    send_word(build_word(tvc_pkg::OP_SET, pool_key[1], 15'h5555, 1'b0, 1'b0));
    pool_tid_guess[0] = '0;
    pool_tid_guess[1] = 15'h5555;
    // Fill the rest of the table. The near-miss keys must land in slots of
    // their own rather than hitting the base key.
    for (slot = 2; slot < tvc_pkg::CACHE_ENTRIES; slot++) begin
      tid = (slot == 5) ? 15'h7FFF : (slot == 6) ? 15'd0 : tvc_pkg::tid_t'($urandom());
      pool_tid_guess[slot] = tid;
      send_word(build_word(tvc_pkg::OP_VALIDATE, pool_key[slot], tid, 1'b0, 1'b0));
    end
    // The table is now full: inserts are dropped, the rest behave as before.
    send_word(build_word(tvc_pkg::OP_VALIDATE, fresh_key(), 15'd42, 1'b0, 1'b0));
    send_word(build_word(tvc_pkg::OP_VALIDATE, fresh_key(), 15'd42, 1'b1, 1'b0));
    send_word(build_word(tvc_pkg::OP_VALIDATE, fresh_key(), 15'd42, 1'b0, 1'b1));
    send_word(build_word(tvc_pkg::OP_SET, fresh_key(), 15'd42, 1'b0, 1'b0));

    // Random part, one block of words per window setting. Every change of the
    // window happens with the block drained and idle, so the sender's full
    // pause is exercised at each boundary.
    for (s = 0; s < SETTINGS_COUNT; s++) begin
      drain_results();
      repeat (2) @(negedge clk);
      cfg_word = $urandom();
      cfg_word[14:0] = window_plan[s];
      cfg_access(1'b1, cfg_word);
      cfg_access(1'b0, '0);
      psel <= 1'b0;
      window_now = window_plan[s];
      settings_run++;

      for (n = 0; n < WORDS_PER_SETTING; n++) begin
        slot = $urandom_range(0, tvc_pkg::CACHE_ENTRIES - 1);
        flavor = $urandom_range(0, 99);
        w = build_word(tvc_pkg::OP_VALIDATE, pool_key[slot], '0, 1'b0,
                       1'($urandom_range(0, 1)));
        if (flavor < 60) begin
          // Known initiator: ids are steered to the repeat, the window edges
          // and just behind, with some fully random ones mixed in.
          case ($urandom_range(0, 5))
            0:       tid = pool_tid_guess[slot];
            1:       tid = pool_tid_guess[slot] + 1'b1;
            2:       tid = pool_tid_guess[slot] + window_now;
            3:       tid = pool_tid_guess[slot] + window_now + 1'b1;
            4:       tid = pool_tid_guess[slot] - 1'b1;
            default: tid = tvc_pkg::tid_t'($urandom());
          endcase
          w.received_tid = tid;
          fwd_gap = tid - pool_tid_guess[slot];
          if (fwd_gap != '0 && fwd_gap <= window_now) pool_tid_guess[slot] = tid;
        end else if (flavor < 70) begin
          w.opcode = tvc_pkg::OP_SET;
          w.received_tid = tvc_pkg::tid_t'($urandom());
          w.new_flag = 1'($urandom_range(0, 1));
          pool_tid_guess[slot] = w.received_tid;
        end else if (flavor < 78) begin
          w.new_flag = 1'b1;
          w.received_tid = tvc_pkg::tid_t'($urandom());
          pool_tid_guess[slot] = '0;
        end else if (flavor < 90) begin
          // Unknown initiators: either a fresh key or a pooled key with a
          // single bit flipped somewhere in the four-tuple.
          if (flavor < 85) k = fresh_key();
          else k = pool_key[slot] ^ (tvc_pkg::key_t'(1) << $urandom_range(0, 95));
          w = build_word(1'($urandom_range(0, 1)), k, tvc_pkg::tid_t'($urandom()),
                         1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
        end else begin
          noise = {$urandom(), $urandom(), $urandom(), $urandom()};
          w = noise[$bits(tvc_pkg::in_word_t)-1:0];
        end
        send_word(w);
        // Now and then the sender also waits for the pipeline to empty
        // in the middle of a block.
        if ($urandom_range(0, 149) == 0) drain_results();
      end
    end

    drain_results();
    // Keep running so that any stray result can still show up.
    repeat (2 * tvc_pkg::CACHE_ENTRIES) @(negedge clk);

    $display("Sent %0d words under %0d window settings, including 0 and 32767.",
             words_sent, settings_run);
    $display("Results: %0d ok, %0d fail, %0d no cached id, %0d set miss; %0d inserts dropped.",
             status_seen[tvc_pkg::ST_OK], status_seen[tvc_pkg::ST_FAIL],
             status_seen[tvc_pkg::ST_NO_CACHE], status_seen[tvc_pkg::ST_NOT_FOUND],
             drops_seen);
    if (mismatch_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

  // Watchdog: a correct run needs well under a tenth of this.
  initial begin
    #10_000_000;
    $display("Simulation FAILED");
    $finish;
  end

endmodule

/* files.f */
src/tvc_pkg.sv
src/tid_window_validation_cache.sv
src/tvc_checker.sv
bench/tvc_checker.sv
bench/tb_top.sv
